### rtl/wpdq_pkg.sv
package wpdq_pkg;

  // request codes
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  // queue / priority codes
  localparam logic [1:0] PRI_HIGH   = 2'd0;
  localparam logic [1:0] PRI_MEDIUM = 2'd1;
  localparam logic [1:0] PRI_LOW    = 2'd2;
  localparam logic [1:0] PRI_EXTRA  = 2'd3;

  localparam int NUM_QUEUES = 3;

  // configuration register indexes
  localparam logic CFG_HIGH_LIMIT   = 1'b0;
  localparam logic CFG_MEDIUM_LIMIT = 1'b1;

  // burst limit reset values
  localparam logic [3:0] HIGH_LIMIT_RST   = 4'd5;
  localparam logic [3:0] MEDIUM_LIMIT_RST = 4'd5;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DEQUEUED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic        op;
    logic [1:0]  priority_req;
    logic [31:0] execute_id;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] granted_id;
    logic [1:0]  granted_priority;
  } out_item_t;

endpackage

### rtl/wpdq_ram.sv
module wpdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read port that holds when idle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/weighted_priority_dequeue_unit.sv
// channel | dir | handshake            | payload
// in      | in  | in_valid / in_ready  | in_data (op, priority_req, execute_id)
// out     | out | out_valid / out_ready| out_data (status, granted_id, granted_priority)
// cfg     | in  | cfg_valid / cfg_ready| cfg_index, cfg_data (burst limits)
//
// one request per cycle while in_ready is high; each result passes through the
// queue ram read stage, then the output register
// the queue head/tail pointers, occupancies and burst counters update at the
// input transfer, so back-to-back requests see each other's effect
// synchronous active-low reset empties all queues and restores both limits to 5
// a stalled output holds one result in the output register and one in the
// read stage; in_ready drops only when both are full
module weighted_priority_dequeue_unit
  import wpdq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_index,
  input  logic [3:0] cfg_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [AW-1:0] head_r [NUM_QUEUES];
  logic [AW-1:0] tail_r [NUM_QUEUES];
  logic [CW-1:0] occ_r  [NUM_QUEUES];
  logic [31:0]   rdata  [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] nonempty;
  logic [NUM_QUEUES-1:0] full;

  logic [3:0] hi_limit_r;
  logic [3:0] md_limit_r;
  logic [3:0] hi_cnt_r, hi_cnt_nxt;
  logic [3:0] md_cnt_r, md_cnt_nxt;

  logic       in_fire;
  logic       cfg_fire;
  logic       s1_move;
  logic       s1_valid_r;
  status_t    s1_status_r;
  logic [1:0] s1_pri_r;
  logic       out_valid_r;
  out_item_t  out_data_r;

  logic [1:0] enq_q;
  logic [1:0] grant_q;
  logic       do_push;
  logic       do_pop;
  status_t    res_status;
  logic [1:0] res_pri;

  // handshakes
  assign s1_move   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_move;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // queue status flags
  always_comb begin
    for (int q = 0; q < NUM_QUEUES; q++) begin
      nonempty[q] = (occ_r[q] != '0);
      full[q]     = (occ_r[q] == CW'(QUEUE_DEPTH));
    end
  end

  // request decision: enqueue target or weighted dequeue grant
  always_comb begin
    enq_q      = (in_data.priority_req == PRI_EXTRA) ? PRI_LOW : in_data.priority_req;
    grant_q    = PRI_HIGH;
    do_push    = 1'b0;
    do_pop     = 1'b0;
    res_status = ST_ENQUEUED;
    res_pri    = enq_q;
    hi_cnt_nxt = hi_cnt_r;
    md_cnt_nxt = md_cnt_r;
    if (in_data.op == OP_ENQUEUE) begin
      if (full[enq_q]) begin
        res_status = ST_FULL;
      end else begin
        do_push = 1'b1;
      end
    end else begin
      res_status = ST_DEQUEUED;
      if (nonempty[PRI_HIGH] && (hi_cnt_r < hi_limit_r)) begin
        hi_cnt_nxt = hi_cnt_r + 4'd1;
        grant_q    = PRI_HIGH;
        do_pop     = 1'b1;
      end else begin
        hi_cnt_nxt = '0;
        if (nonempty[PRI_MEDIUM] && (md_cnt_r < md_limit_r)) begin
          md_cnt_nxt = md_cnt_r + 4'd1;
          grant_q    = PRI_MEDIUM;
          do_pop     = 1'b1;
        end else begin
          md_cnt_nxt = '0;
          // low turn, falling back to the highest non-empty queue
          priority if (nonempty[PRI_LOW]) begin
            grant_q = PRI_LOW;
            do_pop  = 1'b1;
          end else if (nonempty[PRI_HIGH]) begin
            grant_q = PRI_HIGH;
            do_pop  = 1'b1;
          end else if (nonempty[PRI_MEDIUM]) begin
            grant_q = PRI_MEDIUM;
            do_pop  = 1'b1;
          end else begin
            res_status = ST_EMPTY;
          end
        end
      end
      res_pri = grant_q;
    end
  end

  // per-queue pointers and storage
  for (genvar q = 0; q < NUM_QUEUES; q++) begin : g_queue
    logic push;
    logic pop;

    assign push = in_fire && do_push && (enq_q == 2'(q));
    assign pop  = in_fire && do_pop && (grant_q == 2'(q));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        head_r[q] <= '0;
        tail_r[q] <= '0;
        occ_r[q]  <= '0;
      end else if (push) begin
        tail_r[q] <= (tail_r[q] == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_r[q] + AW'(1);
        occ_r[q]  <= occ_r[q] + CW'(1);
      end else if (pop) begin
        head_r[q] <= (head_r[q] == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r[q] + AW'(1);
        occ_r[q]  <= occ_r[q] - CW'(1);
      end
    end

    wpdq_ram #(
      .WIDTH (32),
      .DEPTH (QUEUE_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (push),
      .waddr (tail_r[q]),
      .wdata (in_data.execute_id),
      .re    (pop),
      .raddr (head_r[q]),
      .rdata (rdata[q])
    );
  end

  // burst limits and grant counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_limit_r <= HIGH_LIMIT_RST;
      md_limit_r <= MEDIUM_LIMIT_RST;
      hi_cnt_r   <= '0;
      md_cnt_r   <= '0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_index)
          CFG_HIGH_LIMIT:   hi_limit_r <= cfg_data;
          CFG_MEDIUM_LIMIT: md_limit_r <= cfg_data;
          default:          hi_limit_r <= hi_limit_r;
        endcase
      end
      if (in_fire) begin
        hi_cnt_r <= hi_cnt_nxt;
        md_cnt_r <= md_cnt_nxt;
      end
    end
  end

  // read stage: result tag waits for the ram data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_status_r <= res_status;
      s1_pri_r    <= (res_status == ST_EMPTY) ? PRI_HIGH : res_pri;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r.status           <= s1_status_r;
      out_data_r.granted_id       <= (s1_status_r == ST_DEQUEUED) ? rdata[s1_pri_r] : '0;
      out_data_r.granted_priority <= s1_pri_r;
    end
  end

endmodule
